>>> rtl/lpsf_pkg.sv
// Shared types, codes and helper functions of the LED pixel stream formatter.
package lpsf_pkg;

	// Strip protocol selected by the strip_mode register
	typedef enum logic [1:0] {
		MODE_PLAIN   = 2'd0,
		MODE_1W_RGB  = 2'd1,
		MODE_1W_RGBW = 2'd2,
		MODE_APA     = 2'd3
	} strip_mode_t;

	// Channel order on the line; codes above ORD_GBR send zeros
	typedef enum logic [2:0] {
		ORD_RGB = 3'd0,
		ORD_RBG = 3'd1,
		ORD_GRB = 3'd2,
		ORD_BGR = 3'd3,
		ORD_BRG = 3'd4,
		ORD_GBR = 3'd5
	} color_order_t;

	// Register indexes of the configuration port
	typedef enum logic [2:0] {
		CFG_STRIP_MODE  = 3'd0,
		CFG_COLOR_ORDER = 3'd1,
		CFG_DITHER_EN   = 3'd2,
		CFG_DITHER_PH   = 3'd3,
		CFG_BRIGHTNESS  = 3'd4,
		CFG_ZERO_CODE   = 3'd5,
		CFG_ONE_CODE    = 3'd6
	} cfg_idx_t;

	localparam logic [7:0] APA_HDR_MARK = 8'hE0;
	localparam logic [7:0] CHAN_MAX     = 8'd255;
	localparam logic [1:0] DITHER_MASK  = 2'h3;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = 1;

	// Configuration register file
	typedef struct packed {
		strip_mode_t  strip_mode;
		logic [2:0]   color_order;
		logic         dither_enable;
		logic [1:0]   dither_phase;
		logic [4:0]   apa_brightness;
		logic [3:0]   zero_bit_code;
		logic [3:0]   one_bit_code;
	} cfg_t;

	// One classified pixel, ready for the byte sequencer
	typedef struct packed {
		logic             first;
		logic             last;
		strip_mode_t      mode;
		logic [7:0]       hdr;
		logic [3:0][7:0]  data;
	} job_t;

	// Add one to a channel below full scale when its level beats the phase
	function automatic logic [7:0] dither_ch(input logic [7:0] v, input logic [1:0] level,
			input logic [1:0] phase);
		logic [7:0] r;
		r = v;
		if (v != CHAN_MAX && level > phase) begin
			r = v + 8'd1;
		end
		return r;
	endfunction

endpackage

>>> rtl/lpsf_if.sv
// Valid/ready channel interfaces: pixel input, line byte output, config writes.
interface lpsf_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] extra;
	logic       first_pixel;
	logic       last_pixel;

	modport source (output valid, red, green, blue, extra, first_pixel, last_pixel,
		input ready);
	modport sink (input valid, red, green, blue, extra, first_pixel, last_pixel,
		output ready);
endinterface

interface lpsf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       frame_done;

	modport source (output valid, out_byte, last_of_run, frame_done, input ready);
	modport sink (input valid, out_byte, last_of_run, frame_done, output ready);
endinterface

interface lpsf_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/lpsf_front.sv
// Front end: accepts pixels, applies dither and color order, builds a job.
module lpsf_front (
	lpsf_pixel_if.sink    pix,
	input  lpsf_pkg::cfg_t cfg_regs,
	input  logic          full,
	output logic          push,
	output lpsf_pkg::job_t job
);
	import lpsf_pkg::*;

	logic [7:0] r_d, g_d, b_d;
	logic       dith_on;

	// Take a pixel whenever the queue has room
	assign pix.ready = !full;
	assign push      = pix.valid && !full;

	// Apply temporal dither outside RGBW mode
	assign dith_on = cfg_regs.dither_enable && (cfg_regs.strip_mode != MODE_1W_RGBW);

	always_comb begin
		r_d = pix.red;
		g_d = pix.green;
		b_d = pix.blue;
		if (dith_on) begin
			r_d = dither_ch(pix.red, pix.extra[5:4] & DITHER_MASK, cfg_regs.dither_phase);
			g_d = dither_ch(pix.green, pix.extra[3:2] & DITHER_MASK, cfg_regs.dither_phase);
			b_d = dither_ch(pix.blue, pix.extra[1:0] & DITHER_MASK, cfg_regs.dither_phase);
		end
	end

	// Reorder channels and pack the job
	always_comb begin
		job.first   = pix.first_pixel;
		job.last    = pix.last_pixel;
		job.mode    = cfg_regs.strip_mode;
		job.hdr     = APA_HDR_MARK | {3'd0, cfg_regs.apa_brightness};
		job.data[3] = pix.extra;
		case (color_order_t'(cfg_regs.color_order))
			ORD_RGB: begin job.data[0] = r_d; job.data[1] = g_d; job.data[2] = b_d; end
			ORD_RBG: begin job.data[0] = r_d; job.data[1] = b_d; job.data[2] = g_d; end
			ORD_GRB: begin job.data[0] = g_d; job.data[1] = r_d; job.data[2] = b_d; end
			ORD_BGR: begin job.data[0] = b_d; job.data[1] = g_d; job.data[2] = r_d; end
			ORD_BRG: begin job.data[0] = b_d; job.data[1] = r_d; job.data[2] = g_d; end
			ORD_GBR: begin job.data[0] = g_d; job.data[1] = b_d; job.data[2] = r_d; end
			default: begin job.data[0] = '0; job.data[1] = '0; job.data[2] = '0; end
		endcase
	end

endmodule

>>> rtl/lpsf_fifo.sv
// Two-entry job queue between front end and byte sequencer.
module lpsf_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lpsf_pkg::job_t wr_job,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output lpsf_pkg::job_t rd_job
);
	import lpsf_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push, do_pop;

	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rd_job    = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store jobs
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_job;
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("job queue occupancy out of range");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job pushed into full queue");
`endif

endmodule

>>> rtl/lpsf_back.sv
// Back end: sequences header, data, expansion and trailer bytes into an output register.
module lpsf_back #(
	parameter int TRAILER_BYTES = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lpsf_pkg::cfg_t cfg_regs,
	input  logic           q_valid,
	input  lpsf_pkg::job_t q_job,
	output logic           pop,
	lpsf_byte_if.source    tx
);
	import lpsf_pkg::*;

	localparam int TW         = (TRAILER_BYTES > 1) ? $clog2(TRAILER_BYTES) : 1;
	localparam int TRAIL_LAST = (TRAILER_BYTES > 0) ? TRAILER_BYTES - 1 : 0;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_HEAD  = 5'b00010,
		ST_APA   = 5'b00100,
		ST_DATA  = 5'b01000,
		ST_TRAIL = 5'b10000
	} seq_state_t;

	seq_state_t    state_q, state_nx;
	job_t          job_q;
	logic          head_q;
	logic [1:0]    byte_q, nib_q;
	logic [TW-1:0] trail_q;
	logic          tx_valid_q;
	logic [7:0]    tx_byte_q;
	logic          tx_lor_q, tx_fd_q;

	logic          adv, emit, expand, data_end;
	logic [7:0]    cur_data, shifted, emit_byte;
	seq_state_t    after_head, after_data;

	assign tx.valid       = tx_valid_q;
	assign tx.out_byte    = tx_byte_q;
	assign tx.last_of_run = tx_lor_q;
	assign tx.frame_done  = tx_fd_q;

	// Output register is free when empty or being taken
	assign adv  = !tx_valid_q || tx.ready;
	assign emit = adv && (state_q != ST_IDLE);
	assign pop  = (state_q == ST_IDLE) && q_valid;

	// Select data byte and the two bits of the current expansion step
	assign expand   = (job_q.mode == MODE_1W_RGB) || (job_q.mode == MODE_1W_RGBW);
	assign cur_data = job_q.data[byte_q];
	assign shifted  = cur_data << {nib_q, 1'b0};
	assign data_end = expand ?
		((nib_q == 2'd3) && (byte_q == ((job_q.mode == MODE_1W_RGBW) ? 2'd3 : 2'd2))) :
		(byte_q == 2'd2);

	assign after_head = (job_q.mode == MODE_APA) ? ST_APA : ST_DATA;
	assign after_data = (job_q.last && (TRAILER_BYTES > 0)) ? ST_TRAIL : ST_IDLE;

	// Pick the byte and the next state
	always_comb begin
		emit_byte = '0;
		state_nx  = state_q;
		case (state_q)
			ST_HEAD: begin
				if (head_q) state_nx = after_head;
			end
			ST_APA: begin
				emit_byte = job_q.hdr;
				state_nx  = ST_DATA;
			end
			ST_DATA: begin
				if (expand) begin
					emit_byte = {shifted[7] ? cfg_regs.one_bit_code : cfg_regs.zero_bit_code,
						shifted[6] ? cfg_regs.one_bit_code : cfg_regs.zero_bit_code};
				end else begin
					emit_byte = cur_data;
				end
				if (data_end) state_nx = after_data;
			end
			ST_TRAIL: begin
				if (trail_q == TW'(TRAIL_LAST)) state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= 1'b0;
			byte_q     <= '0;
			nib_q      <= '0;
			trail_q    <= '0;
			tx_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				head_q  <= 1'b0;
				byte_q  <= '0;
				nib_q   <= '0;
				trail_q <= '0;
				if (q_job.first) begin
					state_q <= ST_HEAD;
				end else if (q_job.mode == MODE_APA) begin
					state_q <= ST_APA;
				end else begin
					state_q <= ST_DATA;
				end
			end else if (emit) begin
				state_q <= state_nx;
				if (state_q == ST_HEAD) head_q <= 1'b1;
				if (state_q == ST_TRAIL) trail_q <= trail_q + 1'b1;
				if (state_q == ST_DATA) begin
					if (expand) begin
						nib_q <= nib_q + 2'd1;
						if (nib_q == 2'd3) byte_q <= byte_q + 2'd1;
					end else begin
						byte_q <= byte_q + 2'd1;
					end
				end
			end
			if (emit) begin
				tx_valid_q <= 1'b1;
			end else if (tx.ready) begin
				tx_valid_q <= 1'b0;
			end
		end
	end

	// Load job and output payload
	always_ff @(posedge clk) begin
		if (pop) job_q <= q_job;
		if (emit) begin
			tx_byte_q <= emit_byte;
			tx_lor_q  <= (state_nx == ST_IDLE);
			tx_fd_q   <= (state_nx == ST_IDLE) && job_q.last;
		end
	end

`ifndef SYNTH
	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid_q && tx_fd_q |-> tx_lor_q)
		else $error("frame_done without last_of_run");
	a_run_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit && (state_nx == ST_IDLE) |=> (state_q == ST_IDLE))
		else $error("sequencer did not return to idle after final byte");
`endif

endmodule

>>> rtl/led_pixel_stream_formatter.sv
// Top level of the LED pixel stream formatter: config registers, front, queue and back.
//
// Usage:
//   pix  - pixel input channel (red, green, blue, extra, first_pixel, last_pixel).
//   tx   - line byte output channel (out_byte, last_of_run, frame_done), one byte
//          per transaction, in strip order.
//   cfg  - register write channel, always ready; write only while no pixel is
//          in flight. Index 7 is ignored.
//   A pixel produces 3 to 18 + TRAILER_BYTES bytes: two zero bytes if it opens
//   a frame, the APA102 header byte in that mode, 3 data bytes (12 or 16 in the
//   one-wire modes) and TRAILER_BYTES zero bytes if it closes a frame.
//   The byte sequencer sends one byte per cycle while the receiver is ready and
//   passes through its idle state to load each pixel from the two-entry queue.
//   The first byte of a pixel passes through the queue, the job register and
//   the output register before it appears on tx. The front end keeps taking
//   pixels while the queue has room.
//   Reset empties the queue and the output register and loads the register
//   defaults. When the receiver stalls, the output byte holds and the back end
//   waits; pix stalls once the queue fills.
module led_pixel_stream_formatter #(
	parameter int TRAILER_BYTES = 8
) (
	input logic         clk,
	input logic         arst_n,
	lpsf_pixel_if.sink  pix,
	lpsf_cfg_if.sink    cfg,
	lpsf_byte_if.source tx
);
	import lpsf_pkg::*;

	cfg_t cfg_q;
	logic push, full, q_valid, pop;
	job_t in_job, q_job;

	assign cfg.ready = 1'b1;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.strip_mode     <= MODE_1W_RGB;
			cfg_q.color_order    <= ORD_GRB;
			cfg_q.dither_enable  <= 1'b0;
			cfg_q.dither_phase   <= 2'd0;
			cfg_q.apa_brightness <= 5'd31;
			cfg_q.zero_bit_code  <= 4'd8;
			cfg_q.one_bit_code   <= 4'd14;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_STRIP_MODE:  cfg_q.strip_mode     <= strip_mode_t'(cfg.data[1:0]);
				CFG_COLOR_ORDER: cfg_q.color_order    <= cfg.data[2:0];
				CFG_DITHER_EN:   cfg_q.dither_enable  <= cfg.data[0];
				CFG_DITHER_PH:   cfg_q.dither_phase   <= cfg.data[1:0];
				CFG_BRIGHTNESS:  cfg_q.apa_brightness <= cfg.data[4:0];
				CFG_ZERO_CODE:   cfg_q.zero_bit_code  <= cfg.data[3:0];
				CFG_ONE_CODE:    cfg_q.one_bit_code   <= cfg.data[3:0];
				default: begin
				end
			endcase
		end
	end

	lpsf_front u_front (
		.pix      (pix),
		.cfg_regs (cfg_q),
		.full     (full),
		.push     (push),
		.job      (in_job)
	);

	lpsf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_job    (in_job),
		.pop       (pop),
		.full      (full),
		.not_empty (q_valid),
		.rd_job    (q_job)
	);

	lpsf_back #(
		.TRAILER_BYTES (TRAILER_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_regs (cfg_q),
		.q_valid  (q_valid),
		.q_job    (q_job),
		.pop      (pop),
		.tx       (tx)
	);

endmodule

>>> tb/led_pixel_stream_formatter_test.sv
// Self-checking testbench of the LED pixel stream formatter: directed table, then random frames.
`timescale 1ns / 100ps

module led_pixel_stream_formatter_test;
	import lpsf_pkg::*;

	localparam int TRAILER_LEN = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT    = 28;
	localparam int PHASE_COUNT = 6;
	localparam int PHASE_ITEMS = 26;

	// Color order codes that carry no channel mapping
	localparam logic [2:0] ORD_NONE_LO    = 3'd6;
	localparam logic [2:0] ORD_NONE_HI    = 3'd7;
	// Register index that maps to no register
	localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] extra;
		logic       first;
		logic       last;
	} pixel_t;

	typedef struct packed {
		logic [7:0] val;
		logic       run_end;
		logic       frame_end;
	} line_byte_t;

	typedef enum logic { ROW_WRITE, ROW_PIXEL } row_kind_t;

	// One directed step: a register write, or a pixel with an optional typed result
	// (gold_n bytes all equal to gold_byte; gold_n of zero means use the predictor)
	typedef struct packed {
		row_kind_t  kind;
		logic [2:0] reg_idx;
		logic [7:0] reg_data;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] extra;
		logic       first;
		logic       last;
		logic [4:0] gold_n;
		logic [7:0] gold_byte;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 38;

	// Register fields are unused on pixel rows
	localparam stim_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
		'{ROW_PIXEL, CFG_STRIP_MODE,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 5'd12, 8'h88},
		'{ROW_PIXEL, CFG_STRIP_MODE,  8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 5'd12, 8'hEE},
		'{ROW_PIXEL, CFG_STRIP_MODE,  8'h00, 8'h5A, 8'hA5, 8'h3C, 8'h00, 1'b1, 1'b0, 5'd0, 8'h00},
		'{ROW_PIXEL, CFG_STRIP_MODE,  8'h00, 8'h81, 8'h7E, 8'h01, 8'h00, 1'b0, 1'b1, 5'd0, 8'h00},
		'{ROW_WRITE, CFG_COLOR_ORDER, 8'(ORD_NONE_HI), 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
			5'd0, 8'h00},
		'{ROW_WRITE, CFG_STRIP_MODE,  8'(MODE_PLAIN), 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
			5'd0, 8'h00},
		'{ROW_PIXEL, CFG_STRIP_MODE,  8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1, 1'b1, 5'd13, 8'h00},
		'{ROW_WRITE, CFG_COLOR_ORDER, 8'(ORD_NONE_LO), 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
			5'd0, 8'h00},
		'{ROW_PIXEL, CFG_STRIP_MODE,  8'h00, 8'h12, 8'h34, 8'h56, 8'h00, 1'b0, 1'b0, 5'd3, 8'h00},
		'{ROW_WRITE, CFG_STRIP_MODE,  8'(MODE_1W_RGB), 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
			5'd0, 8'h00},
		'{ROW_PIXEL, CFG_STRIP_MODE,  8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0, 1'b0, 5'd12, 8'h88},
		'{ROW_WRITE, CFG_ZERO_CODE,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_WRITE, CFG_ONE_CODE,    8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_WRITE, CFG_COLOR_ORDER, 8'(ORD_RGB), 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 5'd0,
			8'h00},
		'{ROW_PIXEL, CFG_STRIP_MODE,  8'h00, 8'hFF, 8'h00, 8'h0F, 8'h00, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_PIXEL, CFG_STRIP_MODE,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 5'd22, 8'h00},
		'{ROW_WRITE, CFG_STRIP_MODE,  8'(MODE_1W_RGBW), 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
			5'd0, 8'h00},
		'{ROW_WRITE, CFG_DITHER_EN,   8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_PIXEL, CFG_STRIP_MODE,  8'h00, 8'h01, 8'hFE, 8'h80, 8'hA5, 1'b1, 1'b1, 5'd0, 8'h00},
		'{ROW_WRITE, CFG_STRIP_MODE,  8'(MODE_APA), 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 5'd0,
			8'h00},
		'{ROW_WRITE, CFG_BRIGHTNESS,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_WRITE, CFG_COLOR_ORDER, 8'(ORD_BGR), 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 5'd0,
			8'h00},
		'{ROW_PIXEL, CFG_STRIP_MODE,  8'h00, 8'h11, 8'h22, 8'h33, 8'h00, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_WRITE, CFG_BRIGHTNESS,  8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_WRITE, CFG_COLOR_ORDER, 8'(ORD_BRG), 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 5'd0,
			8'h00},
		'{ROW_PIXEL, CFG_STRIP_MODE,  8'h00, 8'hFE, 8'hFF, 8'h00, 8'h3F, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_WRITE, CFG_DITHER_PH,   8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_WRITE, CFG_COLOR_ORDER, 8'(ORD_GBR), 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 5'd0,
			8'h00},
		'{ROW_PIXEL, CFG_STRIP_MODE,  8'h00, 8'hFE, 8'hFE, 8'hFE, 8'h3F, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_WRITE, CFG_DITHER_PH,   8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_WRITE, CFG_COLOR_ORDER, 8'(ORD_RBG), 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 5'd0,
			8'h00},
		'{ROW_PIXEL, CFG_STRIP_MODE,  8'h00, 8'h10, 8'h20, 8'h30, 8'h27, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_WRITE, CFG_UNUSED_IDX,  8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_PIXEL, CFG_STRIP_MODE,  8'h00, 8'h10, 8'h20, 8'h30, 8'h27, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_WRITE, CFG_STRIP_MODE,  8'(MODE_PLAIN), 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
			5'd0, 8'h00},
		'{ROW_WRITE, CFG_COLOR_ORDER, 8'(ORD_GRB), 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 5'd0,
			8'h00},
		'{ROW_PIXEL, CFG_STRIP_MODE,  8'h00, 8'h00, 8'h00, 8'h00, 8'hC0, 1'b1, 1'b1, 5'd13, 8'h00},
		'{ROW_PIXEL, CFG_STRIP_MODE,  8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h3F, 1'b0, 1'b0, 5'd3, 8'hFF}
	};

	logic clk;
	logic arst_n;

	lpsf_pixel_if pix ();
	lpsf_cfg_if   cfg ();
	lpsf_byte_if  tx ();

	led_pixel_stream_formatter #(
		.TRAILER_BYTES(TRAILER_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix),
		.cfg(cfg),
		.tx(tx)
	);

	cfg_t       reg_shadow;
	line_byte_t expected_bytes [$];
	int         mismatch_count = 0;
	int         cycle_count = 0;
	bit         calm_run;

	// Free-running clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Random idle decision shared by both sides; never idle during a calm stretch
	function automatic bit take_gap();
		return !calm_run && ($urandom_range(99) < IDLE_PCT);
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		mismatch_count++;
		if (mismatch_count <= 40) begin
			$display("mismatch at cycle %0d: %s got %02h want %02h", cycle_count, what, got, want);
		end
	endtask

	function automatic logic [3:0] bit_code(input logic b);
		return b ? reg_shadow.one_bit_code : reg_shadow.zero_bit_code;
	endfunction

	// Bump a channel below full scale when its dither level beats the phase
	function automatic logic [7:0] dithered(input logic [7:0] v, input logic [1:0] lvl);
		if (v != CHAN_MAX && lvl > reg_shadow.dither_phase) begin
			return v + 8'd1;
		end
		return v;
	endfunction

	// Expand one data byte to four line bytes, two data bits per line byte, MSB first
	function automatic void push_expanded(inout logic [7:0] seq [$], input logic [7:0] v);
		for (int k = 0; k < 4; k++) begin
			seq.push_back({bit_code(v[7 - 2 * k]), bit_code(v[6 - 2 * k])});
		end
	endfunction

	// Work out the line bytes of one pixel under the current register settings
	function automatic void predict_line_bytes(input pixel_t p);
		logic [7:0] seq [$];
		logic [7:0] r, g, b;
		logic [7:0] d0, d1, d2;
		r = p.red;
		g = p.green;
		b = p.blue;
		if (p.first) begin
			seq.push_back(8'h00);
			seq.push_back(8'h00);
		end
		if (reg_shadow.strip_mode != MODE_1W_RGBW && reg_shadow.dither_enable) begin
			r = dithered(r, p.extra[5:4]);
			g = dithered(g, p.extra[3:2]);
			b = dithered(b, p.extra[1:0]);
		end
		if (reg_shadow.strip_mode == MODE_APA) begin
			seq.push_back(APA_HDR_MARK | {3'b000, reg_shadow.apa_brightness});
		end
		case (reg_shadow.color_order)
			ORD_RGB: begin d0 = r; d1 = g; d2 = b; end
			ORD_RBG: begin d0 = r; d1 = b; d2 = g; end
			ORD_GRB: begin d0 = g; d1 = r; d2 = b; end
			ORD_BGR: begin d0 = b; d1 = g; d2 = r; end
			ORD_BRG: begin d0 = b; d1 = r; d2 = g; end
			ORD_GBR: begin d0 = g; d1 = b; d2 = r; end
			default: begin d0 = 8'h00; d1 = 8'h00; d2 = 8'h00; end
		endcase
		if (reg_shadow.strip_mode == MODE_1W_RGB || reg_shadow.strip_mode == MODE_1W_RGBW) begin
			push_expanded(seq, d0);
			push_expanded(seq, d1);
			push_expanded(seq, d2);
			if (reg_shadow.strip_mode == MODE_1W_RGBW) begin
				push_expanded(seq, p.extra);
			end
		end else begin
			seq.push_back(d0);
			seq.push_back(d1);
			seq.push_back(d2);
		end
		if (p.last) begin
			for (int t = 0; t < TRAILER_LEN; t++) begin
				seq.push_back(8'h00);
			end
		end
		foreach (seq[i]) begin
			expected_bytes.push_back('{seq[i], i == seq.size() - 1,
				(i == seq.size() - 1) && p.last});
		end
	endfunction

	// Offer one pixel, hold it until the transaction, then queue what it should produce
	task automatic send_pixel(input pixel_t p, input int gold_n, input logic [7:0] gold_byte);
		cfg.valid <= 1'b0;
		if (take_gap()) begin
			pix.valid <= 1'b0;
			@(posedge clk);
			while (take_gap()) @(posedge clk);
		end
		pix.valid       <= 1'b1;
		pix.red         <= p.red;
		pix.green       <= p.green;
		pix.blue        <= p.blue;
		pix.extra       <= p.extra;
		pix.first_pixel <= p.first;
		pix.last_pixel  <= p.last;
		@(posedge clk);
		while (!pix.ready) @(posedge clk);
		if (gold_n == 0) begin
			predict_line_bytes(p);
		end else begin
			for (int i = 0; i < gold_n; i++) begin
				expected_bytes.push_back('{gold_byte, i == gold_n - 1,
					(i == gold_n - 1) && p.last});
			end
		end
	endtask

	// Stop offering pixels and wait until every expected byte has come out
	task automatic drain();
		pix.valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
	endtask

	// Write one register; the shadow copy keeps only the register's width
	task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		case (idx)
			CFG_STRIP_MODE:  reg_shadow.strip_mode     = strip_mode_t'(value[1:0]);
			CFG_COLOR_ORDER: reg_shadow.color_order    = value[2:0];
			CFG_DITHER_EN:   reg_shadow.dither_enable  = value[0];
			CFG_DITHER_PH:   reg_shadow.dither_phase   = value[1:0];
			CFG_BRIGHTNESS:  reg_shadow.apa_brightness = value[4:0];
			CFG_ZERO_CODE:   reg_shadow.zero_bit_code  = value[3:0];
			CFG_ONE_CODE:    reg_shadow.one_bit_code   = value[3:0];
			default: ;
		endcase
	endtask

	// Check each output transaction against the oldest expectation; stall at random
	always @(posedge clk) begin
		line_byte_t want;
		if (arst_n && tx.valid && tx.ready) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch("byte with nothing expected", tx.out_byte, 8'h00);
			end else begin
				want = expected_bytes.pop_front();
				if (tx.out_byte !== want.val) begin
					report_mismatch("out_byte", tx.out_byte, want.val);
				end
				if (tx.last_of_run !== want.run_end) begin
					report_mismatch("last_of_run", {7'd0, tx.last_of_run}, {7'd0, want.run_end});
				end
				if (tx.frame_done !== want.frame_end) begin
					report_mismatch("frame_done", {7'd0, tx.frame_done}, {7'd0, want.frame_end});
				end
			end
		end
		tx.ready <= !take_gap();
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		stim_row_t  row;
		pixel_t     px;
		logic [1:0] phase_mode;
		int         frame_left;
		int         frame_pos;

		calm_run       = 1'b0;
		frame_left     = 0;
		frame_pos      = 0;
		reg_shadow     = '{strip_mode: MODE_1W_RGB, color_order: ORD_GRB, dither_enable: 1'b0,
			dither_phase: 2'd0, apa_brightness: 5'd31, zero_bit_code: 4'd8, one_bit_code: 4'd14};

		arst_n          <= 1'b0;
		pix.valid       <= 1'b0;
		pix.red         <= 8'h00;
		pix.green       <= 8'h00;
		pix.blue        <= 8'h00;
		pix.extra       <= 8'h00;
		pix.first_pixel <= 1'b0;
		pix.last_pixel  <= 1'b0;
		cfg.valid       <= 1'b0;
		cfg.index       <= CFG_STRIP_MODE;
		cfg.data        <= 8'h00;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			row = DIRECTED_TABLE[i];
			if (row.kind == ROW_WRITE) begin
				drain();
				write_reg(row.reg_idx, row.reg_data);
			end else begin
				px = '{row.red, row.green, row.blue, row.extra, row.first, row.last};
				send_pixel(px, row.gold_n, row.gold_byte);
			end
		end

		// Random phases: all-low and all-high settings first, then each strip mode
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			drain();
			calm_run = (ph == 3);
			phase_mode = 2'(ph - 2);
			if (ph == 0) begin
				for (int idx = CFG_STRIP_MODE; idx <= CFG_ONE_CODE; idx++) begin
					write_reg(3'(idx), 8'h00);
				end
			end else if (ph == 1) begin
				for (int idx = CFG_STRIP_MODE; idx <= CFG_ONE_CODE; idx++) begin
					write_reg(3'(idx), 8'hFF);
				end
			end else begin
				write_reg(CFG_STRIP_MODE, {6'($urandom), phase_mode});
				for (int idx = CFG_COLOR_ORDER; idx <= CFG_ONE_CODE; idx++) begin
					write_reg(3'(idx), 8'($urandom));
				end
			end
			write_reg(CFG_UNUSED_IDX, 8'($urandom));

			// Mostly well-formed frames of one to six pixels, some with stray flags
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (frame_left == 0) begin
					frame_left = $urandom_range(6, 1);
					frame_pos  = 0;
				end
				px.red   = 8'($urandom);
				px.green = 8'($urandom);
				px.blue  = 8'($urandom);
				px.extra = 8'($urandom);
				px.first = (frame_pos == 0);
				px.last  = (frame_left == 1);
				if ($urandom_range(99) < 15) begin
					px.first = 1'($urandom);
					px.last  = 1'($urandom);
				end
				frame_left--;
				frame_pos++;
				send_pixel(px, 0, 8'h00);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/lpsf_pkg.sv
rtl/lpsf_if.sv
rtl/lpsf_front.sv
rtl/lpsf_fifo.sv
rtl/lpsf_back.sv
rtl/led_pixel_stream_formatter.sv
tb/led_pixel_stream_formatter_test.sv
